[rtl/core/nmiirq_pkg.sv]
// Package for the NMI / H-V timer IRQ unit: field widths, codes, reset values
// and the shared item and result types. No dependencies.
package nmiirq_pkg;

   localparam int unsigned KIND_W   = 3;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned VCOUNT_W = 9;
   localparam int unsigned HCOUNT_W = 11;
   localparam int unsigned CSR_W    = 9;
   localparam int unsigned APB_DW   = 32;
   localparam int unsigned APB_AW   = 4;

   localparam int unsigned EN_HIRQ_BIT = 4;
   localparam int unsigned EN_VIRQ_BIT = 5;
   localparam int unsigned EN_NMI_BIT  = 7;

   localparam logic [CSR_W-1:0] DISPLAY_HEIGHT_RST = CSR_W'(225);
   localparam logic [CSR_W-1:0] VIRQ_LINE_RST     = CSR_W'(511);
   localparam logic [CSR_W-1:0] HIRQ_DOT_RST      = CSR_W'(511);

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK     = 3'd0,
      KIND_WRITE    = 3'd1,
      KIND_NMI_READ = 3'd2,
      KIND_IRQ_READ = 3'd3,
      KIND_NMI_TEST = 3'd4,
      KIND_IRQ_TEST = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      REG_DISPLAY_HEIGHT = 2'd0,
      REG_VIRQ_LINE      = 2'd1,
      REG_HIRQ_DOT       = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [BYTE_W-1:0]   write_byte;
      logic [VCOUNT_W-1:0] vertical_count_late2;
      logic [VCOUNT_W-1:0] vertical_count_late10;
      logic [HCOUNT_W-1:0] horizontal_count_late10;
      logic                cpu_irq_request;
      logic                cpu_irq_disable;
   } item_type;

   typedef struct packed {
      logic answer_bit;
      logic wake_cpu;
      logic irq_lock_pulse;
   } result_type;

   typedef struct packed {
      logic nmi_enabled;
      logic hpos_irq_enabled;
      logic vpos_irq_enabled;
      logic timer_irq_enabled;
      logic nmi_valid;
      logic nmi_line;
      logic nmi_hold;
      logic nmi_transition;
      logic irq_valid;
      logic irq_line;
      logic irq_hold;
      logic irq_transition;
   } state_type;

endpackage

[rtl/core/nmiirq_req_if.sv]
// Request channel of the NMI / timer IRQ unit: valid, ready and event payload.
// Depends on nmiirq_pkg.
interface nmiirq_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [nmiirq_pkg::KIND_W-1:0]         kind;
   logic [nmiirq_pkg::BYTE_W-1:0]         write_byte;
   logic [nmiirq_pkg::VCOUNT_W-1:0]       vertical_count_late2;
   logic [nmiirq_pkg::VCOUNT_W-1:0]       vertical_count_late10;
   logic [nmiirq_pkg::HCOUNT_W-1:0]       horizontal_count_late10;
   logic                                  cpu_irq_request;
   logic                                  cpu_irq_disable;

   modport source (
      output valid, kind, write_byte, vertical_count_late2, vertical_count_late10,
             horizontal_count_late10, cpu_irq_request, cpu_irq_disable,
      input  ready
   );
   modport sink (
      input  valid, kind, write_byte, vertical_count_late2, vertical_count_late10,
             horizontal_count_late10, cpu_irq_request, cpu_irq_disable,
      output ready
   );
endinterface

[rtl/core/nmiirq_rsp_if.sv]
// Response channel of the NMI / timer IRQ unit: valid, ready and result bits.
// No dependencies.
interface nmiirq_rsp_if;
   logic valid;
   logic ready;
   logic answer_bit;
   logic wake_cpu;
   logic irq_lock_pulse;

   modport source (
      output valid, answer_bit, wake_cpu, irq_lock_pulse,
      input  ready
   );
   modport sink (
      input  valid, answer_bit, wake_cpu, irq_lock_pulse,
      output ready
   );
endinterface

[rtl/core/nmi_irq_timer_interrupt_unit.sv]
// NMI and H/V position timer IRQ unit of a console CPU.
// Depends on nmiirq_pkg, nmiirq_req_if and nmiirq_rsp_if.
// An accepted transaction is held in the input register, and its result then in the output register that drives rsp.
// Throughput: one transaction per cycle; while rsp is stalled the input register takes one
// more transaction, then req ready drops until the waiting result is taken.
// Reset (synchronous): clears all flags, loads the register defaults, empties both stages.
module nmi_irq_timer_interrupt_unit (
   input  logic                                clock,
   input  logic                                reset,
   nmiirq_req_if.sink                          req_if,
   nmiirq_rsp_if.source                        rsp_if,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [nmiirq_pkg::APB_AW-1:0]       paddr,
   input  logic [nmiirq_pkg::APB_DW-1:0]       pwdata,
   output logic [nmiirq_pkg::APB_DW-1:0]       prdata,
   output logic                                pready
);
   import nmiirq_pkg::*;

   logic [CSR_W-1:0]  display_height_ff;
   logic [CSR_W-1:0]  virq_line_ff;
   logic [CSR_W-1:0]  hirq_dot_ff;
   reg_index_type     csr_index;
   logic              csr_write;

   logic              s1_valid_ff;
   item_type          s1_item_ff;
   logic              out_valid_ff;
   result_type        out_result_ff;
   state_type         state_ff;

   state_type         state_in;
   result_type        result_in;
   logic              advance;
   logic              nmi_valid_now;
   logic              irq_cond;
   logic [HCOUNT_W:0] h_target;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[APB_AW-1:2]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      prdata = '0;
      case (csr_index)
         REG_DISPLAY_HEIGHT: prdata = APB_DW'(display_height_ff);
         REG_VIRQ_LINE:      prdata = APB_DW'(virq_line_ff);
         REG_HIRQ_DOT:       prdata = APB_DW'(hirq_dot_ff);
         default:            prdata = '0;
      endcase
   end

   assign advance       = !out_valid_ff || rsp_if.ready;
   assign req_if.ready  = !s1_valid_ff || advance;

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.answer_bit     = out_result_ff.answer_bit;
   assign rsp_if.wake_cpu       = out_result_ff.wake_cpu;
   assign rsp_if.irq_lock_pulse = out_result_ff.irq_lock_pulse;

   assign h_target      = {({1'b0, hirq_dot_ff} + (CSR_W+1)'(1)), 2'b00};
   assign nmi_valid_now = s1_item_ff.vertical_count_late2 >= display_height_ff;
   assign irq_cond      = state_ff.timer_irq_enabled
      && (!state_ff.vpos_irq_enabled || s1_item_ff.vertical_count_late10 == virq_line_ff)
      && (!state_ff.hpos_irq_enabled
          || {1'b0, s1_item_ff.horizontal_count_late10} == h_target);

   always_comb begin
      state_in  = state_ff;
      result_in = '0;
      case (kind_type'(s1_item_ff.kind))
         KIND_TICK: begin
            if (state_ff.nmi_hold) begin
               state_in.nmi_hold = 1'b0;
               if (state_ff.nmi_enabled) state_in.nmi_transition = 1'b1;
            end
            if (nmi_valid_now != state_ff.nmi_valid) begin
               state_in.nmi_valid = nmi_valid_now;
               state_in.nmi_line  = nmi_valid_now;
               if (nmi_valid_now) state_in.nmi_hold = 1'b1;
            end
            state_in.irq_hold = 1'b0;
            if (state_ff.irq_line && state_ff.timer_irq_enabled) begin
               state_in.irq_transition = 1'b1;
            end
            if (!state_ff.irq_valid && irq_cond) begin
               state_in.irq_line = 1'b1;
               state_in.irq_hold = 1'b1;
            end
            state_in.irq_valid = irq_cond;
         end
         KIND_WRITE: begin
            state_in.hpos_irq_enabled  = s1_item_ff.write_byte[EN_HIRQ_BIT];
            state_in.vpos_irq_enabled  = s1_item_ff.write_byte[EN_VIRQ_BIT];
            state_in.timer_irq_enabled = s1_item_ff.write_byte[EN_HIRQ_BIT]
                                         || s1_item_ff.write_byte[EN_VIRQ_BIT];
            if (s1_item_ff.write_byte[EN_VIRQ_BIT] && !s1_item_ff.write_byte[EN_HIRQ_BIT]
                && state_ff.irq_line) begin
               state_in.irq_transition = 1'b1;
            end else if (!state_in.timer_irq_enabled) begin
               state_in.irq_line       = 1'b0;
               state_in.irq_transition = 1'b0;
            end
            if (!state_ff.nmi_enabled && s1_item_ff.write_byte[EN_NMI_BIT]
                && state_ff.nmi_line) begin
               state_in.nmi_transition = 1'b1;
            end
            state_in.nmi_enabled     = s1_item_ff.write_byte[EN_NMI_BIT];
            result_in.irq_lock_pulse = 1'b1;
         end
         KIND_NMI_READ: begin
            result_in.answer_bit = state_ff.nmi_line;
            if (!state_ff.nmi_hold) state_in.nmi_line = 1'b0;
         end
         KIND_IRQ_READ: begin
            result_in.answer_bit = state_ff.irq_line;
            if (!state_ff.irq_hold) begin
               state_in.irq_line       = 1'b0;
               state_in.irq_transition = 1'b0;
            end
         end
         KIND_NMI_TEST: begin
            if (state_ff.nmi_transition) begin
               state_in.nmi_transition = 1'b0;
               result_in.wake_cpu      = 1'b1;
               result_in.answer_bit    = 1'b1;
            end
         end
         KIND_IRQ_TEST: begin
            if (state_ff.irq_transition || s1_item_ff.cpu_irq_request) begin
               state_in.irq_transition = 1'b0;
               result_in.wake_cpu      = 1'b1;
               result_in.answer_bit    = !s1_item_ff.cpu_irq_disable;
            end
         end
         default: begin
            state_in  = state_ff;
            result_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         display_height_ff <= DISPLAY_HEIGHT_RST;
         virq_line_ff      <= VIRQ_LINE_RST;
         hirq_dot_ff       <= HIRQ_DOT_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_DISPLAY_HEIGHT: display_height_ff <= pwdata[CSR_W-1:0];
            REG_VIRQ_LINE:      virq_line_ff      <= pwdata[CSR_W-1:0];
            REG_HIRQ_DOT:       hirq_dot_ff       <= pwdata[CSR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_if.ready) s1_valid_ff <= req_if.valid;
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         s1_item_ff.kind                    <= req_if.kind;
         s1_item_ff.write_byte              <= req_if.write_byte;
         s1_item_ff.vertical_count_late2    <= req_if.vertical_count_late2;
         s1_item_ff.vertical_count_late10   <= req_if.vertical_count_late10;
         s1_item_ff.horizontal_count_late10 <= req_if.horizontal_count_late10;
         s1_item_ff.cpu_irq_request         <= req_if.cpu_irq_request;
         s1_item_ff.cpu_irq_disable         <= req_if.cpu_irq_disable;
      end
      if (advance && s1_valid_ff) out_result_ff <= result_in;
   end

endmodule
